FILE: rtl/tlt_pkg.sv
// Shared constants, types and the arctangent table for the tilt to corner heights block.
`default_nettype none

package tlt_pkg;

   // Input sample handling.
   localparam int ACCEL_BITS = 16;

   // CORDIC configuration.
   localparam int CORDIC_STEPS = 16;
   localparam int TAB_LEN = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
   localparam int CORDIC_LAT = CORDIC_ITERS + 1;

   // Square root: one result bit per stage.
   localparam int SQRT_BITS = 32;
   localparam int SQRT_IN_BITS = 2 * SQRT_BITS;
   localparam int SQRT_LAT = SQRT_BITS;

   // Quotient units: one quotient bit per stage plus a clamping stage.
   localparam int NUM_BITS = 35;
   localparam int FB_QBITS = 16;
   localparam int FB_LAT = FB_QBITS + 1;
   localparam int LR_QBITS = 17;
   localparam int LR_LAT = LR_QBITS + 1;

   // Datapath widths.
   localparam int CW = 36;
   localparam int AW = 28;
   localparam int TW = 23;

   typedef logic signed [CW-1:0] cordic_word_type;
   typedef logic signed [AW-1:0] angle_type;
   typedef logic signed [15:0] height_type;

   // Sign and zero flags that travel with a quotient.
   typedef struct packed {
      logic neg;
      logic zero;
   } sign_flags_type;

   localparam angle_type DEG90 = angle_type'(90 * 65536);
   localparam angle_type DEG180 = angle_type'(180 * 65536);

   // atan(2^-i) in degrees with 16 fractional bits, rounded.
   localparam logic [TW-1:0] ATAN_TAB [TAB_LEN] = '{
      23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
      23'd234379, 23'd117304, 23'd58666, 23'd29335,
      23'd14668, 23'd7334, 23'd3667, 23'd1833,
      23'd917, 23'd458, 23'd229, 23'd115,
      23'd57, 23'd29, 23'd14, 23'd7,
      23'd4, 23'd2, 23'd1, 23'd0
   };

   // Configuration register indices and reset values.
   localparam int CSR_INDEX_BITS = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LENGTH = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH = 4'd1;
   localparam logic [15:0] LENGTH_RESET = 16'd500;
   localparam logic [15:0] WIDTH_RESET = 16'd200;

endpackage

`default_nettype wire

FILE: rtl/tlt_isqrt.sv
// Pipelined integer square root, one result bit resolved per register stage.
`default_nettype none

module tlt_isqrt (
   input  logic                               clock,
   input  logic [tlt_pkg::SQRT_IN_BITS-1:0]   v_in,
   output logic [tlt_pkg::SQRT_BITS-1:0]      root_out
);
   import tlt_pkg::*;

   logic [SQRT_IN_BITS-1:0] rem_ff [SQRT_BITS];
   logic [SQRT_BITS-1:0]    res_ff [SQRT_BITS];

   for (genvar j = 0; j < SQRT_BITS; j++) begin : g_stage
      localparam int B = SQRT_BITS - 1 - j;
      logic [SQRT_IN_BITS-1:0] rem_prev;
      logic [SQRT_IN_BITS-1:0] trial;
      logic [SQRT_BITS-1:0]    res_prev;

      if (j == 0) begin : g_head
         assign rem_prev = v_in;
         assign res_prev = '0;
      end else begin : g_tail
         assign rem_prev = rem_ff[j-1];
         assign res_prev = res_ff[j-1];
      end

      // Setting bit B is allowed when the remainder covers 2*res*2^B + 4^B.
      assign trial = ({{SQRT_BITS{1'b0}}, res_prev} << (B + 1))
                   | ({{(SQRT_IN_BITS-1){1'b0}}, 1'b1} << (2 * B));

      always_ff @(posedge clock) begin
         if (rem_prev >= trial) begin
            rem_ff[j] <= rem_prev - trial;
            res_ff[j] <= res_prev | ({{(SQRT_BITS-1){1'b0}}, 1'b1} << B);
         end else begin
            rem_ff[j] <= rem_prev;
            res_ff[j] <= res_prev;
         end
      end
   end

   assign root_out = res_ff[SQRT_BITS-1];

endmodule

`default_nettype wire

FILE: rtl/tlt_cordic.sv
// Pipelined CORDIC vectoring unit giving atan2 in degrees with 16 fractional bits.
`default_nettype none

module tlt_cordic (
   input  logic                      clock,
   input  tlt_pkg::cordic_word_type  y_in,
   input  tlt_pkg::cordic_word_type  x_in,
   output tlt_pkg::angle_type        angle_out
);
   import tlt_pkg::*;

   cordic_word_type x_ff [CORDIC_LAT];
   cordic_word_type y_ff [CORDIC_LAT];
   angle_type       a_ff [CORDIC_LAT];

   // Front stage: settle the level and vertical cases and fold the left half-plane.
   // A settled case clears y so that the iterations leave it alone.
   always_ff @(posedge clock) begin
      priority if (y_in == '0) begin
         x_ff[0] <= x_in;
         y_ff[0] <= '0;
         a_ff[0] <= x_in[CW-1] ? DEG180 : '0;
      end else if (x_in == '0) begin
         x_ff[0] <= x_in;
         y_ff[0] <= '0;
         a_ff[0] <= y_in[CW-1] ? -DEG90 : DEG90;
      end else if (x_in[CW-1]) begin
         x_ff[0] <= -x_in;
         y_ff[0] <= -y_in;
         a_ff[0] <= y_in[CW-1] ? -DEG180 : DEG180;
      end else begin
         x_ff[0] <= x_in;
         y_ff[0] <= y_in;
         a_ff[0] <= '0;
      end
   end

   // One micro-rotation per stage.
   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      cordic_word_type dx;
      cordic_word_type dy;
      angle_type       step;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign step = {{(AW-TW){1'b0}}, ATAN_TAB[i]};

      always_ff @(posedge clock) begin
         priority if (y_ff[i] == '0) begin
            x_ff[i+1] <= x_ff[i];
            y_ff[i+1] <= y_ff[i];
            a_ff[i+1] <= a_ff[i];
         end else if (!y_ff[i][CW-1]) begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            a_ff[i+1] <= a_ff[i] + step;
         end else begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            a_ff[i+1] <= a_ff[i] - step;
         end
      end
   end

   assign angle_out = a_ff[CORDIC_ITERS];

endmodule

`default_nettype wire

FILE: rtl/tlt_fb_div.sv
// Pipelined quotient by a square root: largest q with q*q*s <= n*n, saturated to 16 bits.
`default_nettype none

module tlt_fb_div (
   input  logic                            clock,
   input  logic [31:0]                     s_in,
   input  logic [63:0]                     n2_in,
   input  logic                            big_in,
   input  tlt_pkg::sign_flags_type         flags_in,
   output tlt_pkg::height_type             fb_out
);
   import tlt_pkg::*;

   logic [63:0]          a_ff   [FB_QBITS];
   logic [47:0]          b_ff   [FB_QBITS];
   logic [FB_QBITS-1:0]  q_ff   [FB_QBITS];
   logic [31:0]          s_ff   [FB_QBITS];
   logic [63:0]          n2_ff  [FB_QBITS];
   logic                 big_ff [FB_QBITS];
   sign_flags_type       flg_ff [FB_QBITS];
   height_type           fb_ff;

   // Each stage tries one quotient bit, keeping q*q*s and q*s up to date with adds only.
   for (genvar j = 0; j < FB_QBITS; j++) begin : g_stage
      localparam int K = FB_QBITS - 1 - j;
      logic [63:0]         a_prev;
      logic [47:0]         b_prev;
      logic [FB_QBITS-1:0] q_prev;
      logic [31:0]         s_prev;
      logic [63:0]         n2_prev;
      logic                big_prev;
      sign_flags_type      flg_prev;
      logic [63:0]         trial;

      if (j == 0) begin : g_head
         assign a_prev = '0;
         assign b_prev = '0;
         assign q_prev = '0;
         assign s_prev = s_in;
         assign n2_prev = n2_in;
         assign big_prev = big_in;
         assign flg_prev = flags_in;
      end else begin : g_tail
         assign a_prev = a_ff[j-1];
         assign b_prev = b_ff[j-1];
         assign q_prev = q_ff[j-1];
         assign s_prev = s_ff[j-1];
         assign n2_prev = n2_ff[j-1];
         assign big_prev = big_ff[j-1];
         assign flg_prev = flg_ff[j-1];
      end

      assign trial = a_prev + ({16'b0, b_prev} << (K + 1)) + ({32'b0, s_prev} << (2 * K));

      always_ff @(posedge clock) begin
         s_ff[j] <= s_prev;
         n2_ff[j] <= n2_prev;
         big_ff[j] <= big_prev;
         flg_ff[j] <= flg_prev;
         if (trial <= n2_prev) begin
            a_ff[j] <= trial;
            b_ff[j] <= b_prev + ({16'b0, s_prev} << K);
            q_ff[j] <= q_prev | ({{(FB_QBITS-1){1'b0}}, 1'b1} << K);
         end else begin
            a_ff[j] <= a_prev;
            b_ff[j] <= b_prev;
            q_ff[j] <= q_prev;
         end
      end
   end

   // Clamp to the signed 16-bit range and apply the sign.
   logic [16:0]    cap;
   logic [16:0]    qx;
   logic [16:0]    mag;
   sign_flags_type flg_last;

   assign flg_last = flg_ff[FB_QBITS-1];
   assign cap = flg_last.neg ? 17'd32768 : 17'd32767;
   assign qx = {{(17-FB_QBITS){1'b0}}, q_ff[FB_QBITS-1]};
   assign mag = (big_ff[FB_QBITS-1] || (qx > cap)) ? cap : qx;

   always_ff @(posedge clock) begin
      if (flg_last.zero) begin
         fb_ff <= '0;
      end else if (flg_last.neg) begin
         fb_ff <= height_type'(-mag);
      end else begin
         fb_ff <= height_type'(mag);
      end
   end

   assign fb_out = fb_ff;

endmodule

`default_nettype wire

FILE: rtl/tlt_lr_div.sv
// Pipelined restoring divider giving a truncated signed quotient saturated to 16 bits.
`default_nettype none

module tlt_lr_div (
   input  logic                              clock,
   input  logic [tlt_pkg::NUM_BITS-1:0]      num_in,
   input  logic [15:0]                       d_in,
   input  tlt_pkg::sign_flags_type           flags_in,
   output tlt_pkg::height_type               lr_out
);
   import tlt_pkg::*;

   logic [NUM_BITS-1:0]  rem_ff [LR_QBITS];
   logic [LR_QBITS-1:0]  q_ff   [LR_QBITS];
   logic [15:0]          d_ff   [LR_QBITS];
   logic                 ovf_ff [LR_QBITS];
   sign_flags_type       flg_ff [LR_QBITS];
   height_type           lr_ff;
   logic                 ovf_first;

   // A quotient that needs more bits than the stages give saturates anyway.
   assign ovf_first = {1'b0, num_in} >= ({{(NUM_BITS+1-16){1'b0}}, d_in} << LR_QBITS);

   for (genvar j = 0; j < LR_QBITS; j++) begin : g_stage
      localparam int K = LR_QBITS - 1 - j;
      logic [NUM_BITS-1:0] rem_prev;
      logic [LR_QBITS-1:0] q_prev;
      logic [15:0]         d_prev;
      logic                ovf_prev;
      sign_flags_type      flg_prev;
      logic [NUM_BITS-1:0] dsh;

      if (j == 0) begin : g_head
         assign rem_prev = num_in;
         assign q_prev = '0;
         assign d_prev = d_in;
         assign ovf_prev = ovf_first;
         assign flg_prev = flags_in;
      end else begin : g_tail
         assign rem_prev = rem_ff[j-1];
         assign q_prev = q_ff[j-1];
         assign d_prev = d_ff[j-1];
         assign ovf_prev = ovf_ff[j-1];
         assign flg_prev = flg_ff[j-1];
      end

      assign dsh = {{(NUM_BITS-16){1'b0}}, d_prev} << K;

      always_ff @(posedge clock) begin
         d_ff[j] <= d_prev;
         ovf_ff[j] <= ovf_prev;
         flg_ff[j] <= flg_prev;
         if (rem_prev >= dsh) begin
            rem_ff[j] <= rem_prev - dsh;
            q_ff[j] <= q_prev | ({{(LR_QBITS-1){1'b0}}, 1'b1} << K);
         end else begin
            rem_ff[j] <= rem_prev;
            q_ff[j] <= q_prev;
         end
      end
   end

   // Clamp to the signed 16-bit range and apply the sign.
   logic [16:0]    cap;
   logic [16:0]    qx;
   logic [16:0]    mag;
   sign_flags_type flg_last;

   assign flg_last = flg_ff[LR_QBITS-1];
   assign cap = flg_last.neg ? 17'd32768 : 17'd32767;
   assign qx = 17'(q_ff[LR_QBITS-1]);
   assign mag = (ovf_ff[LR_QBITS-1] || (qx > cap)) ? cap : qx;

   always_ff @(posedge clock) begin
      if (flg_last.zero) begin
         lr_ff <= '0;
      end else if (flg_last.neg) begin
         lr_ff <= height_type'(-mag);
      end else begin
         lr_ff <= height_type'(mag);
      end
   end

   assign lr_out = lr_ff;

endmodule

`default_nettype wire

FILE: rtl/accel_tilt_to_corner_heights.sv
// Top level: accelerometer vector to pitch, roll, height differences and corner heights.
// The block takes one vector on every clock cycle and never raises busy. Each result appears
// on the rsp_ ports for one cycle with rsp_strobe high, after two input stages, the 32-stage
// square root of (y*y+z*z)*2^32, the 17-stage pitch CORDIC that works on that root, and two
// output stages. The receiver cannot hold results off, so it must take each one in the cycle
// it is shown. The vehicle length and width registers are written through the csr_ port, which
// is always ready, and must only be changed while no vectors are in flight.
`default_nettype none

module accel_tilt_to_corner_heights (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [15:0]                   req_accel_x,
   input  logic signed [15:0]                   req_accel_y,
   input  logic signed [15:0]                   req_accel_z,
   output logic                                 rsp_strobe,
   output logic signed [14:0]                   rsp_pitch_centideg,
   output logic signed [15:0]                   rsp_roll_centideg,
   output logic signed [15:0]                   rsp_front_back_mm,
   output logic signed [15:0]                   rsp_left_right_mm,
   output logic [15:0]                          rsp_corner_front_left,
   output logic [15:0]                          rsp_corner_front_right,
   output logic [15:0]                          rsp_corner_rear_left,
   output logic [15:0]                          rsp_corner_rear_right,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tlt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [15:0]                          csr_wdata
);
   import tlt_pkg::*;

   localparam int EXT = 16 - ACCEL_BITS;
   localparam int ALIGN = 1 + SQRT_LAT + CORDIC_LAT;
   localparam int PIPE_LEN = ALIGN + 3;
   localparam int ROLL_DLY = SQRT_LAT;
   localparam int FB_DLY = ALIGN - 1 - FB_LAT;
   localparam int LR_DLY = ALIGN - 1 - LR_LAT;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers.
   logic [15:0] len_ff;
   logic [15:0] wid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LENGTH_RESET;
         wid_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LENGTH: len_ff <= csr_wdata;
            CSR_WIDTH:  wid_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Valid bits travel alongside the data.
   logic [PIPE_LEN-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_LEN-2:0], start & ~busy};
      end
   end

   // Input stage: sign extension, squares and the scaled numerators.
   logic signed [15:0] ax_in;
   logic signed [15:0] ay_in;
   logic signed [15:0] az_in;
   logic [15:0]        abs_x;
   logic [15:0]        abs_y;
   logic [19:0]        len10;
   logic [19:0]        wid10;
   logic [35:0]        nfb_prod;
   logic [35:0]        nlr_prod;
   logic signed [31:0] ysq_prod;
   logic signed [31:0] zsq_prod;

   assign ax_in = (req_accel_x <<< EXT) >>> EXT;
   assign ay_in = (req_accel_y <<< EXT) >>> EXT;
   assign az_in = (req_accel_z <<< EXT) >>> EXT;
   assign abs_x = ax_in[15] ? 16'(-ax_in) : 16'(ax_in);
   assign abs_y = ay_in[15] ? 16'(-ay_in) : 16'(ay_in);
   assign len10 = ({4'b0, len_ff} << 3) + ({4'b0, len_ff} << 1);
   assign wid10 = ({4'b0, wid_ff} << 3) + ({4'b0, wid_ff} << 1);
   assign nfb_prod = len10 * abs_x;
   assign nlr_prod = wid10 * abs_y;
   assign ysq_prod = ay_in * ay_in;
   assign zsq_prod = az_in * az_in;

   logic signed [15:0]  x1_ff;
   logic signed [15:0]  y1_ff;
   logic signed [15:0]  z1_ff;
   logic [30:0]         ysq1_ff;
   logic [30:0]         zsq1_ff;
   logic [NUM_BITS-1:0] nfb1_ff;
   logic [NUM_BITS-1:0] nlr1_ff;

   always_ff @(posedge clock) begin
      x1_ff <= ax_in;
      y1_ff <= ay_in;
      z1_ff <= az_in;
      ysq1_ff <= ysq_prod[30:0];
      zsq1_ff <= zsq_prod[30:0];
      nfb1_ff <= nfb_prod[NUM_BITS-1:0];
      nlr1_ff <= nlr_prod[NUM_BITS-1:0];
   end

   // Second stage: sum of squares, squared numerator and the sign and zero flags.
   logic [31:0]         s2_ff;
   logic [63:0]         n2_2_ff;
   logic                fbbig2_ff;
   sign_flags_type      fbflg2_ff;
   logic [NUM_BITS-1:0] nlr2_ff;
   logic [15:0]         d2_ff;
   sign_flags_type      lrflg2_ff;
   logic signed [15:0]  x2_ff;
   logic signed [15:0]  y2_ff;
   logic signed [15:0]  z2_ff;

   always_ff @(posedge clock) begin
      s2_ff <= {1'b0, ysq1_ff} + {1'b0, zsq1_ff};
      n2_2_ff <= nfb1_ff[31:0] * nfb1_ff[31:0];
      fbbig2_ff <= |nfb1_ff[NUM_BITS-1:32];
      fbflg2_ff.neg <= x1_ff[15];
      fbflg2_ff.zero <= (nfb1_ff == '0);
      nlr2_ff <= nlr1_ff;
      d2_ff <= z1_ff[15] ? 16'(-z1_ff) : 16'(z1_ff);
      lrflg2_ff.neg <= y1_ff[15] ^ z1_ff[15];
      lrflg2_ff.zero <= (nlr1_ff == '0);
      x2_ff <= x1_ff;
      y2_ff <= y1_ff;
      z2_ff <= z1_ff;
   end

   // Square root of (y*y+z*z)*2^32.
   logic [SQRT_BITS-1:0] root;

   tlt_isqrt u_sqrt (
      .clock    (clock),
      .v_in     ({s2_ff, 32'b0}),
      .root_out (root)
   );

   // Roll angle.
   cordic_word_type roll_y;
   cordic_word_type roll_x;
   angle_type       roll_ang;

   assign roll_y = {{(CW-32){y2_ff[15]}}, y2_ff, 16'b0};
   assign roll_x = {{(CW-32){z2_ff[15]}}, z2_ff, 16'b0};

   tlt_cordic u_roll (
      .clock     (clock),
      .y_in      (roll_y),
      .x_in      (roll_x),
      .angle_out (roll_ang)
   );

   // Front-back and left-right height differences.
   height_type fb_unit;
   height_type lr_unit;

   tlt_fb_div u_fb (
      .clock    (clock),
      .s_in     (s2_ff),
      .n2_in    (n2_2_ff),
      .big_in   (fbbig2_ff),
      .flags_in (fbflg2_ff),
      .fb_out   (fb_unit)
   );

   tlt_lr_div u_lr (
      .clock    (clock),
      .num_in   (nlr2_ff),
      .d_in     (d2_ff),
      .flags_in (lrflg2_ff),
      .lr_out   (lr_unit)
   );

   // Delay lines that line x up with the root and the side results up with the pitch angle.
   logic signed [15:0] x_dly_ff    [SQRT_LAT];
   angle_type          roll_dly_ff [ROLL_DLY];
   height_type         fb_dly_ff   [FB_DLY];
   height_type         lr_dly_ff   [LR_DLY];

   always_ff @(posedge clock) begin
      x_dly_ff[0] <= x2_ff;
      for (int i = 1; i < SQRT_LAT; i++) begin
         x_dly_ff[i] <= x_dly_ff[i-1];
      end
      roll_dly_ff[0] <= roll_ang;
      for (int i = 1; i < ROLL_DLY; i++) begin
         roll_dly_ff[i] <= roll_dly_ff[i-1];
      end
      fb_dly_ff[0] <= fb_unit;
      for (int i = 1; i < FB_DLY; i++) begin
         fb_dly_ff[i] <= fb_dly_ff[i-1];
      end
      lr_dly_ff[0] <= lr_unit;
      for (int i = 1; i < LR_DLY; i++) begin
         lr_dly_ff[i] <= lr_dly_ff[i-1];
      end
   end

   // Pitch angle from x against the root.
   cordic_word_type   pitch_y;
   cordic_word_type   pitch_x;
   angle_type         pitch_ang;
   logic signed [15:0] x_late;

   assign x_late = x_dly_ff[SQRT_LAT-1];
   assign pitch_y = {{(CW-32){x_late[15]}}, x_late, 16'b0};
   assign pitch_x = {{(CW-SQRT_BITS){1'b0}}, root};

   tlt_cordic u_pitch (
      .clock     (clock),
      .y_in      (pitch_y),
      .x_in      (pitch_x),
      .angle_out (pitch_ang)
   );

   // First output stage: scale the angles by 100 and halve the differences toward zero.
   height_type         fb_al;
   height_type         lr_al;
   height_type         fbh_in;
   height_type         lrh_in;
   logic signed [31:0] p100_ff;
   logic signed [31:0] r100_ff;
   height_type         fb3_ff;
   height_type         lr3_ff;
   height_type         fbh_ff;
   height_type         lrh_ff;

   assign fb_al = fb_dly_ff[FB_DLY-1];
   assign lr_al = lr_dly_ff[LR_DLY-1];
   assign fbh_in = (fb_al + $signed({15'b0, fb_al[15]})) >>> 1;
   assign lrh_in = (lr_al + $signed({15'b0, lr_al[15]})) >>> 1;

   always_ff @(posedge clock) begin
      p100_ff <= 32'(pitch_ang) * 32'sd100;
      r100_ff <= 32'(roll_dly_ff[ROLL_DLY-1]) * 32'sd100;
      fb3_ff <= fb_al;
      lr3_ff <= lr_al;
      fbh_ff <= fbh_in;
      lrh_ff <= lrh_in;
   end

   // Second output stage: drop the fraction toward zero and lift the corners off the lowest one.
   logic signed [31:0] pitch_q;
   logic signed [31:0] roll_q;
   logic signed [17:0] fbe;
   logic signed [17:0] lre;
   logic signed [17:0] lift;
   logic signed [17:0] c0;
   logic signed [17:0] c1;
   logic signed [17:0] c2;
   logic signed [17:0] c3;

   assign pitch_q = (p100_ff + $signed({16'b0, {16{p100_ff[31]}}})) >>> 16;
   assign roll_q = (r100_ff + $signed({16'b0, {16{r100_ff[31]}}})) >>> 16;
   assign fbe = 18'(fbh_ff);
   assign lre = 18'(lrh_ff);
   assign lift = (fbe[17] ? -fbe : fbe) + (lre[17] ? -lre : lre);
   assign c0 = fbe + lre + lift;
   assign c1 = fbe - lre + lift;
   assign c2 = -fbe + lre + lift;
   assign c3 = -fbe - lre + lift;

   function automatic logic [15:0] sat_corner(logic signed [17:0] v);
      return (v > 18'sd65535) ? 16'hFFFF : v[15:0];
   endfunction

   always_ff @(posedge clock) begin
      rsp_pitch_centideg <= pitch_q[14:0];
      rsp_roll_centideg <= roll_q[15:0];
      rsp_front_back_mm <= fb3_ff;
      rsp_left_right_mm <= lr3_ff;
      rsp_corner_front_left <= sat_corner(c0);
      rsp_corner_front_right <= sat_corner(c1);
      rsp_corner_rear_left <= sat_corner(c2);
      rsp_corner_rear_right <= sat_corner(c3);
   end

   assign rsp_strobe = vld_ff[PIPE_LEN-1];

endmodule

`default_nettype wire
